### rtl/hjsd_pkg.sv
// ============================================================================
// hjsd_pkg
// Shared types and fixed widths for the hex8 shape-derivative unit.
// ============================================================================
package hjsd_pkg;

    localparam int NODES  = 8;
    localparam int NAT_W  = 16;   // natural coordinate, Q1.14
    localparam int CRD_W  = 32;   // coordinate port width, Q16.16
    localparam int OUT_W  = 32;   // global derivative width
    localparam int DET_W  = 64;   // reported determinant width
    localparam int DN_W   = 34;   // dN/dnat, units 2^-31
    localparam int JAC_W  = 37;   // rounded Jacobian entry, units 2^-16
    localparam int A_W    = 76;   // multiplicand: coordinate, Jacobian or cofactor
    localparam int B_W    = 40;   // multiplier: dN/dnat or Jacobian
    localparam int ACC_W  = A_W + B_W;
    localparam int DIG_W  = 4;    // multiplier digit per cycle
    localparam int N_DIG  = B_W / DIG_W;
    localparam int QW     = 31;   // quotient bits below the saturation point

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [2:0]              node_index;
        logic signed [CRD_W-1:0] coord_x;
        logic signed [CRD_W-1:0] coord_y;
        logic signed [CRD_W-1:0] coord_z;
        logic signed [NAT_W-1:0] point_r;
        logic signed [NAT_W-1:0] point_s;
        logic signed [NAT_W-1:0] point_t;
    } hjsd_cmd_t;

    typedef struct packed {
        logic [2:0]              out_node;
        logic signed [OUT_W-1:0] dn_dx;
        logic signed [OUT_W-1:0] dn_dy;
        logic signed [OUT_W-1:0] dn_dz;
        logic signed [DET_W-1:0] jac_det;
        logic                    bad_geometry;
        logic                    last;
    } hjsd_result_t;

    typedef struct packed {
        logic start;   // load operands and run one product
        logic clr;     // clear the accumulator first
        logic sub;     // subtract the product instead of adding
    } hjsd_mul_ctl_t;

endpackage

### rtl/hex8_jacobian_shape_derivs_top.sv
// ============================================================================
// hex8_jacobian_shape_derivs_top
// Global shape-function derivatives of an 8-node trilinear hexahedron.
// ============================================================================
// Usage:
//   A command beat is taken when start is high and busy is low.
//   func = load: node_index's x/y/z are written in that cycle, busy stays low,
//     nothing comes out. Only the low min(COORD_WIDTH,32) bits are kept.
//   func = evaluate: busy rises and the block forms dN/dnat for the point,
//     the Jacobian, its cofactors and determinant, then per node and axis
//     one signed divide. Eight result beats follow, node 0 first, each on
//     result for one cycle with result_valid high; last marks node 7.
//   Work: every product runs through one shared multiplier that takes
//     4 multiplier bits a cycle. The Jacobian, cofactors and determinant
//     cost 93 products, each derivative 3 products plus a divide that
//     yields 1 quotient bit per cycle; with bad geometry the derivative
//     work is skipped.
//   One item at a time: busy falls in the cycle that carries the eighth beat.
//   The receiver cannot stall; every beat must be taken as it appears.
//   Reset clears the sequencer and the result strobe. Node storage is not
//   cleared; every node must be loaded before an evaluation.
// ============================================================================
module hex8_jacobian_shape_derivs_top
    import hjsd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  hjsd_cmd_t    cmd,
    output logic         result_valid,
    output hjsd_result_t result
);

    localparam int SW = (COORD_WIDTH < CRD_W) ? COORD_WIDTH : CRD_W;
    localparam int DS_W = ACC_W - 32;
    localparam logic signed [16:0] NAT_ONE = 17'sd16384;
    localparam logic signed [ACC_W-1:0] JAC_HALF = ACC_W'(1) << 30;
    localparam logic signed [ACC_W-1:0] DET_HALF = ACC_W'(1) << 31;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_JISS  = 13'b0000000000010,
        S_JWAIT = 13'b0000000000100,
        S_CISS  = 13'b0000000001000,
        S_CWAIT = 13'b0000000010000,
        S_DISS  = 13'b0000000100000,
        S_DWAIT = 13'b0000001000000,
        S_DFIN  = 13'b0000010000000,
        S_NISS  = 13'b0000100000000,
        S_NWAIT = 13'b0001000000000,
        S_VISS  = 13'b0010000000000,
        S_VWAIT = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

    // dN/dnat of node k along natural axis ax, units 2^-31 (1/8 folded in)
    function automatic logic signed [DN_W-1:0] dn_calc(
        input logic signed [NAT_W-1:0] r,
        input logic signed [NAT_W-1:0] s,
        input logic signed [NAT_W-1:0] t,
        input logic [2:0]              k,
        input logic [1:0]              ax
    );
        logic signed [16:0]     f0;
        logic signed [16:0]     f1;
        logic signed [16:0]     f2;
        logic signed [DN_W-1:0] pr;
        logic                   sgn;
        f0 = (k[0] ^ k[1]) ? NAT_ONE + 17'(r) : NAT_ONE - 17'(r);
        f1 = k[1] ? NAT_ONE + 17'(s) : NAT_ONE - 17'(s);
        f2 = k[2] ? NAT_ONE + 17'(t) : NAT_ONE - 17'(t);
        case (ax)
            2'd0:
            begin
                pr  = f1 * f2;
                sgn = k[0] ^ k[1];
            end
            2'd1:
            begin
                pr  = f0 * f2;
                sgn = k[1];
            end
            default:
            begin
                pr  = f0 * f1;
                sgn = k[2];
            end
        endcase
        return sgn ? pr : -pr;
    endfunction

    function automatic logic [1:0] nx1(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [1:0] nx2(input logic [1:0] i);
        return (i == 2'd0) ? 2'd2 : i - 2'd1;
    endfunction

    state_t                   state_reg;
    logic [1:0]               ci_reg;
    logic [1:0]               cj_reg;
    logic [2:0]               ck_reg;
    logic                     cp_reg;
    logic                     result_valid_reg;
    hjsd_result_t             result_reg;

    logic signed [SW-1:0]     cx_reg [NODES];
    logic signed [SW-1:0]     cy_reg [NODES];
    logic signed [SW-1:0]     cz_reg [NODES];
    logic signed [NAT_W-1:0]  pr_reg;
    logic signed [NAT_W-1:0]  ps_reg;
    logic signed [NAT_W-1:0]  pt_reg;
    logic signed [JAC_W-1:0]  jac_reg [3][3];
    logic signed [A_W-1:0]    cof_reg [3][3];
    logic signed [ACC_W-1:0]  det_reg;
    logic                     bad_reg;
    logic signed [DET_W-1:0]  det_sat_reg;
    logic signed [OUT_W-1:0]  res_reg [3];

    hjsd_mul_ctl_t            mul_ctl;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]  mul_acc;
    logic                     mul_done;
    logic                     div_start;
    logic signed [OUT_W-1:0]  div_quot;
    logic                     div_done;

    logic signed [SW-1:0]     coord_sel;
    logic [1:0]               i1, i2, j1, j2;
    logic signed [ACC_W-1:0]  jac_sum;
    logic signed [JAC_W-1:0]  jac_round;
    logic signed [ACC_W-1:0]  det_rnd;
    logic [DS_W-1:0]          det_sh;
    logic                     det_ovf;
    logic signed [DET_W-1:0]  det_sat;
    logic                     bad_now;
    logic                     ij_last;
    logic                     accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // operand selection for the shared multiplier
    always_comb
    begin
        i1 = nx1(ci_reg);
        i2 = nx2(ci_reg);
        j1 = nx1(cj_reg);
        j2 = nx2(cj_reg);
        case (cj_reg)
            2'd0:    coord_sel = cx_reg[ck_reg];
            2'd1:    coord_sel = cy_reg[ck_reg];
            default: coord_sel = cz_reg[ck_reg];
        endcase
        mul_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_JISS:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.clr   = (ck_reg == 3'd0);
                mul_a = A_W'(coord_sel);
                mul_b = B_W'(dn_calc(pr_reg, ps_reg, pt_reg, ck_reg, ci_reg));
            end
            S_CISS:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.clr   = !cp_reg;
                mul_ctl.sub   = cp_reg;
                if (!cp_reg)
                begin
                    mul_a = A_W'(jac_reg[i1][j1]);
                    mul_b = B_W'(jac_reg[i2][j2]);
                end
                else
                begin
                    mul_a = A_W'(jac_reg[i1][j2]);
                    mul_b = B_W'(jac_reg[i2][j1]);
                end
            end
            S_DISS:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.clr   = (cj_reg == 2'd0);
                mul_a = cof_reg[0][cj_reg];
                mul_b = B_W'(jac_reg[0][cj_reg]);
            end
            S_NISS:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.clr   = (cj_reg == 2'd0);
                mul_a = cof_reg[cj_reg][ci_reg];
                mul_b = B_W'(dn_calc(pr_reg, ps_reg, pt_reg, ck_reg, cj_reg));
            end
            default:
                mul_ctl = '0;
        endcase
    end

    // Jacobian rounding, determinant rounding and saturation, bad-geometry test
    always_comb
    begin
        jac_sum   = mul_acc + JAC_HALF;
        jac_round = jac_sum[JAC_W+30:31];
        det_rnd   = det_reg + DET_HALF;
        det_sh    = det_rnd[ACC_W-1:32];
        det_ovf   = !((&det_sh[DS_W-1:DET_W-1]) || !(|det_sh[DS_W-1:DET_W-1]));
        if (det_ovf)
            det_sat = det_sh[DS_W-1] ? {1'b1, {(DET_W-1){1'b0}}}
                                     : {1'b0, {(DET_W-1){1'b1}}};
        else
            det_sat = det_sh[DET_W-1:0];
        bad_now   = det_reg[ACC_W-1] || (det_reg == '0);
        ij_last   = (ci_reg == 2'd2) && (cj_reg == 2'd2);
    end

    assign div_start = (state_reg == S_VISS);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ci_reg           <= '0;
            cj_reg           <= '0;
            ck_reg           <= '0;
            cp_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd.func == FUNC_EVAL))
                    begin
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        ck_reg    <= '0;
                        cp_reg    <= 1'b0;
                        state_reg <= S_JISS;
                    end
                end
                S_JISS:
                    state_reg <= S_JWAIT;
                S_JWAIT:
                begin
                    if (mul_done)
                    begin
                        if (ck_reg != 3'd7)
                        begin
                            ck_reg    <= ck_reg + 3'd1;
                            state_reg <= S_JISS;
                        end
                        else
                        begin
                            ck_reg <= '0;
                            cj_reg <= (cj_reg == 2'd2) ? 2'd0 : cj_reg + 2'd1;
                            if (cj_reg == 2'd2)
                                ci_reg <= (ci_reg == 2'd2) ? 2'd0 : ci_reg + 2'd1;
                            state_reg <= ij_last ? S_CISS : S_JISS;
                        end
                    end
                end
                S_CISS:
                    state_reg <= S_CWAIT;
                S_CWAIT:
                begin
                    if (mul_done)
                    begin
                        if (!cp_reg)
                        begin
                            cp_reg    <= 1'b1;
                            state_reg <= S_CISS;
                        end
                        else
                        begin
                            cp_reg <= 1'b0;
                            cj_reg <= (cj_reg == 2'd2) ? 2'd0 : cj_reg + 2'd1;
                            if (cj_reg == 2'd2)
                                ci_reg <= (ci_reg == 2'd2) ? 2'd0 : ci_reg + 2'd1;
                            state_reg <= ij_last ? S_DISS : S_CISS;
                        end
                    end
                end
                S_DISS:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (mul_done)
                    begin
                        if (cj_reg != 2'd2)
                        begin
                            cj_reg    <= cj_reg + 2'd1;
                            state_reg <= S_DISS;
                        end
                        else
                        begin
                            cj_reg    <= '0;
                            state_reg <= S_DFIN;
                        end
                    end
                end
                S_DFIN:
                begin
                    ci_reg    <= '0;
                    cj_reg    <= '0;
                    ck_reg    <= '0;
                    state_reg <= bad_now ? S_EMIT : S_NISS;
                end
                S_NISS:
                    state_reg <= S_NWAIT;
                S_NWAIT:
                begin
                    if (mul_done)
                    begin
                        if (cj_reg != 2'd2)
                        begin
                            cj_reg    <= cj_reg + 2'd1;
                            state_reg <= S_NISS;
                        end
                        else
                        begin
                            cj_reg    <= '0;
                            state_reg <= S_VISS;
                        end
                    end
                end
                S_VISS:
                    state_reg <= S_VWAIT;
                S_VWAIT:
                begin
                    if (div_done)
                    begin
                        if (ci_reg != 2'd2)
                        begin
                            ci_reg    <= ci_reg + 2'd1;
                            state_reg <= S_NISS;
                        end
                        else
                        begin
                            ci_reg    <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    result_valid_reg <= 1'b1;
                    if (ck_reg == 3'd7)
                    begin
                        ck_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ck_reg    <= ck_reg + 3'd1;
                        state_reg <= bad_reg ? S_EMIT : S_NISS;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.func == FUNC_LOAD))
        begin
            cx_reg[cmd.node_index] <= cmd.coord_x[SW-1:0];
            cy_reg[cmd.node_index] <= cmd.coord_y[SW-1:0];
            cz_reg[cmd.node_index] <= cmd.coord_z[SW-1:0];
        end
        if (accept && (cmd.func == FUNC_EVAL))
        begin
            pr_reg <= cmd.point_r;
            ps_reg <= cmd.point_s;
            pt_reg <= cmd.point_t;
        end
        if ((state_reg == S_JWAIT) && mul_done && (ck_reg == 3'd7))
            jac_reg[ci_reg][cj_reg] <= jac_round;
        if ((state_reg == S_CWAIT) && mul_done && cp_reg)
            cof_reg[ci_reg][cj_reg] <= mul_acc[A_W-1:0];
        if ((state_reg == S_DWAIT) && mul_done && (cj_reg == 2'd2))
            det_reg <= mul_acc;
        if (state_reg == S_DFIN)
        begin
            bad_reg     <= bad_now;
            det_sat_reg <= det_sat;
        end
        if ((state_reg == S_VWAIT) && div_done)
            res_reg[ci_reg] <= div_quot;
        if (state_reg == S_EMIT)
        begin
            result_reg.out_node     <= ck_reg;
            result_reg.dn_dx        <= bad_reg ? '0 : res_reg[0];
            result_reg.dn_dy        <= bad_reg ? '0 : res_reg[1];
            result_reg.dn_dz        <= bad_reg ? '0 : res_reg[2];
            result_reg.jac_det      <= det_sat_reg;
            result_reg.bad_geometry <= bad_reg;
            result_reg.last         <= (ck_reg == 3'd7);
        end
    end

    hjsd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .acc   (mul_acc),
        .done  (mul_done)
    );

    hjsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_acc),
        .den   (det_reg),
        .quot  (div_quot),
        .done  (div_done)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // evaluate command starts the sequencer
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.func == FUNC_EVAL) |=> busy)
        else $error("evaluate beat did not raise busy");

    // load command leaves busy low
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.func == FUNC_LOAD) |=> !busy)
        else $error("load beat raised busy");

    // nothing follows the eighth beat
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("beat after last");

    // bad geometry zeroes the derivatives
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_geometry |->
            (result.dn_dx == '0) && (result.dn_dy == '0) && (result.dn_dz == '0))
        else $error("nonzero derivative with bad geometry");

    // multiplier and divider never finish together
    a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider done together");

endmodule

### rtl/hjsd_mul.sv
// ============================================================================
// hjsd_mul
// Shared digit-serial multiply-accumulate unit, 4 multiplier bits per cycle.
// ============================================================================
module hjsd_mul
    import hjsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  hjsd_mul_ctl_t           ctl,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    done
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_DIG  = 3'b010,
        M_ACC  = 3'b100
    } mstate_t;

    localparam int CNT_W = $clog2(N_DIG);

    mstate_t                  state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     done_reg;
    logic                     sub_reg;
    logic signed [A_W-1:0]    a_reg;
    logic [B_W-1:0]           b_reg;
    logic signed [ACC_W-1:0]  p_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [DIG_W-1:0]         digit;
    logic signed [DIG_W:0]    dig_s;
    logic signed [A_W+DIG_W:0] part;
    logic signed [ACC_W-1:0]  p_next;

    always_comb
    begin
        digit  = b_reg[B_W-1 -: DIG_W];
        // top digit carries the sign, the rest are unsigned
        dig_s  = (cnt_reg == '0) ? {digit[DIG_W-1], digit} : {1'b0, digit};
        part   = a_reg * dig_s;
        p_next = (p_reg <<< DIG_W) + ACC_W'(part);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (ctl.start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= M_DIG;
                    end
                end
                M_DIG:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(N_DIG - 1))
                        state_reg <= M_ACC;
                end
                M_ACC:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                    state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (ctl.start)
                begin
                    a_reg   <= a;
                    b_reg   <= b;
                    sub_reg <= ctl.sub;
                    p_reg   <= '0;
                    if (ctl.clr)
                        acc_reg <= '0;
                end
            end
            M_DIG:
            begin
                p_reg <= p_next;
                b_reg <= b_reg << DIG_W;
            end
            M_ACC:
                acc_reg <= sub_reg ? acc_reg - p_reg : acc_reg + p_reg;
            default:
                p_reg <= p_reg;
        endcase
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### rtl/hjsd_div.sv
// ============================================================================
// hjsd_div
// Restoring divider, one quotient bit per cycle, rounds 2*num/den to nearest.
// ============================================================================
module hjsd_div
    import hjsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic [ACC_W-1:0]        den,   // positive
    output logic signed [OUT_W-1:0] quot,
    output logic                    done
);

    typedef enum logic [3:0] {
        V_IDLE = 4'b0001,
        V_PREP = 4'b0010,
        V_ITER = 4'b0100,
        V_FIN  = 4'b1000
    } vstate_t;

    localparam int UW    = ACC_W + 2;
    localparam int CNT_W = $clog2(QW);

    vstate_t               state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic                  sat_reg;
    logic [UW-1:0]         n_reg;
    logic [UW-1:0]         den_reg;
    logic [UW-1:0]         rem_reg;
    logic [QW-1:0]         nlow_reg;
    logic [QW-1:0]         q_reg;
    logic signed [OUT_W-1:0] quot_reg;

    logic [ACC_W-1:0]      mag;
    logic [UW-1:0]         hi_part;
    logic [UW:0]           trial;
    logic                  ge;
    logic [OUT_W-1:0]      q_ext;

    always_comb
    begin
        mag     = num[ACC_W-1] ? (~num + 1'b1) : num;
        hi_part = UW'(n_reg[UW-1:QW]);
        trial   = {rem_reg, nlow_reg[QW-1]};
        ge      = trial >= {1'b0, den_reg};
        q_ext   = {1'b0, q_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= V_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                V_IDLE:
                    if (start)
                        state_reg <= V_PREP;
                V_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (hi_part >= den_reg) ? V_FIN : V_ITER;
                end
                V_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QW - 1))
                        state_reg <= V_FIN;
                end
                V_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= V_IDLE;
                end
                default:
                    state_reg <= V_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            V_IDLE:
            begin
                if (start)
                begin
                    // floor((4*|num| + den) / (2*den))
                    neg_reg <= num[ACC_W-1];
                    n_reg   <= (UW'(mag) << 2) + UW'(den);
                    den_reg <= UW'(den) << 1;
                end
            end
            V_PREP:
            begin
                sat_reg  <= hi_part >= den_reg;
                rem_reg  <= hi_part;
                nlow_reg <= n_reg[QW-1:0];
                q_reg    <= '0;
            end
            V_ITER:
            begin
                rem_reg  <= ge ? UW'(trial - {1'b0, den_reg}) : trial[UW-1:0];
                q_reg    <= {q_reg[QW-2:0], ge};
                nlow_reg <= nlow_reg << 1;
            end
            V_FIN:
            begin
                if (sat_reg)
                    quot_reg <= neg_reg ? {1'b1, {(OUT_W-1){1'b0}}}
                                        : {1'b0, {(OUT_W-1){1'b1}}};
                else
                    quot_reg <= neg_reg ? (~q_ext + 1'b1) : q_ext;
            end
            default:
                quot_reg <= quot_reg;
        endcase
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule
